>>> src/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/tlik_pkg.sv
// shared types, constants and the cordic angle table for the arm solver
// no dependencies
`default_nettype none
package tlik_pkg;

    localparam int FRAC_BITS_DEF   = 6;
    localparam int CORDIC_ITER_DEF = 16;
    localparam int ANG_FRAC        = 24;
    localparam int ANG_W           = 32;
    localparam int AT_W            = 35;
    localparam int CW              = 57;
    localparam int MX_W            = 53;
    localparam int NORM_STEPS      = 6;
    localparam int SQ_STEPS        = 31;
    localparam int SQ_W            = 62;
    localparam int SQ_TOP          = 60;

    localparam logic signed [ANG_W-1:0] ANG_90 = 32'sd1509949440;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNREACH = 2'd1;
    localparam logic [1:0] ST_DEGEN   = 2'd2;

    localparam logic CFG_FIRST_LINK  = 1'b0;
    localparam logic CFG_SECOND_LINK = 1'b1;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] th;
        logic               unreach;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic signed [33:0] d1;
        logic signed [32:0] p;
        logic signed [31:0] a2y;
    } t_sq;

    typedef struct packed {
        logic zero_den;
        logic num_pos;
        logic degen;
    } t_at_flag;

    function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 32'sd754974720;
            1:  v = 32'sd445687602;
            2:  v = 32'sd235489088;
            3:  v = 32'sd119537938;
            4:  v = 32'sd60000934;
            5:  v = 32'sd30029717;
            6:  v = 32'sd15018523;
            7:  v = 32'sd7509720;
            8:  v = 32'sd3754917;
            9:  v = 32'sd1877466;
            10: v = 32'sd938734;
            11: v = 32'sd469367;
            12: v = 32'sd234684;
            13: v = 32'sd117342;
            14: v = 32'sd58671;
            15: v = 32'sd29335;
            16: v = 32'sd14668;
            17: v = 32'sd7334;
            18: v = 32'sd3667;
            19: v = 32'sd1833;
            20: v = 32'sd917;
            21: v = 32'sd458;
            22: v = 32'sd229;
            23: v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> src/two_link_arm_inverse_kinematics.sv
// two-link arm inverse kinematics solver, fully pipelined
// input beat: target x, y, z and tool angle; output beat: four joint values and status
// link lengths are written on a plain register port (index 0 first link, 1 second)
// by the user only while no beat is in flight; the block does not enforce this.
// both reset to 12800 (200 mm). a beat runs from input to output through five
// product/sum stages, 31 square root stages, the atan lanes (seven fold/normalize
// stages plus one per cordic iteration) and two output stages. one beat can enter
// every cycle while o_stall is low.
// the result sits in an output register; while it is stalled the pipeline keeps
// taking beats until a finished beat reaches the stage in front of it, then o_stall
// rises and everything holds. no beat is lost or repeated.
// reset (synchronous, active low) empties the pipeline and restores the link lengths.
// depends on tlik_pkg, tlik_atan and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module two_link_arm_inverse_kinematics import tlik_pkg::*; #(
    parameter int FRAC_BITS         = FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_target_z,
    input  logic signed [15:0] i_tool_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_shoulder_angle,
    output logic signed [14:0] o_elbow_angle,
    output logic signed [16:0] o_wrist_angle,
    output logic signed [15:0] o_slide_travel,
    output logic [1:0]         o_solve_status
);

    localparam int ATAN_LAT = 1 + NORM_STEPS + CORDIC_ITERATIONS;
    localparam int RW       = 36;
    localparam int OSH      = ANG_FRAC - FRAC_BITS;
    localparam logic signed [RW-1:0] RND = RW'(1) <<< (OSH - 1);

    function automatic logic signed [14:0] sat15(input logic signed [RW-1:0] v);
        logic signed [14:0] r;
        if (v > 36'sd16383)
            r = 15'sh3FFF;
        else if (v < -36'sd16384)
            r = 15'sh4000;
        else
            r = v[14:0];
        return r;
    endfunction

    logic [14:0] r_a1;
    logic [14:0] r_a2;
    logic        w_en;
    logic        r6_valid;
    logic        r_out_valid;

    assign w_en    = !(r6_valid && r_out_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= 15'd12800;
            r_a2 <= 15'd12800;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_LINK:  r_a1 <= i_cfg_data;
                CFG_SECOND_LINK: r_a2 <= i_cfg_data;
            endcase
        end
    end

    // stage 1: products
    logic signed [15:0] w_a1s;
    logic signed [15:0] w_a2s;
    logic signed [15:0] w_df;
    logic [15:0]        w_sm;
    logic signed [31:0] w_xx, w_yy, w_dd, w_ay, w_ax;
    logic [31:0]        w_ss, w_a1sq, w_a2sq;

    assign w_a1s  = $signed({1'b0, r_a1});
    assign w_a2s  = $signed({1'b0, r_a2});
    assign w_df   = w_a1s - w_a2s;
    assign w_sm   = {1'b0, r_a1} + {1'b0, r_a2};
    assign w_xx   = i_target_x * i_target_x;
    assign w_yy   = i_target_y * i_target_y;
    assign w_dd   = w_df * w_df;
    assign w_ss   = w_sm * w_sm;
    assign w_a1sq = r_a1 * r_a1;
    assign w_a2sq = r_a2 * r_a2;
    assign w_ay   = w_a1s * i_target_y;
    assign w_ax   = w_a1s * i_target_x;

    logic               r1_valid;
    logic [30:0]        r1_xx, r1_yy;
    logic [29:0]        r1_dd, r1_a1sq, r1_a2sq;
    logic [31:0]        r1_ss;
    logic signed [31:0] r1_a2y, r1_a2x;
    logic signed [15:0] r1_z, r1_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_xx   <= w_xx[30:0];
            r1_yy   <= w_yy[30:0];
            r1_dd   <= w_dd[29:0];
            r1_ss   <= w_ss;
            r1_a1sq <= w_a1sq[29:0];
            r1_a2sq <= w_a2sq[29:0];
            r1_a2y  <= {w_ay[30:0], 1'b0};
            r1_a2x  <= {w_ax[30:0], 1'b0};
            r1_z    <= i_target_z;
            r1_th   <= i_tool_angle;
        end
    end

    // stage 2: r2, P, Q and part of the shoulder denominator
    logic [31:0]        w_r2;
    logic               r2_valid;
    logic [31:0]        r2_r2;
    logic signed [32:0] r2_p, r2_e;
    logic signed [33:0] r2_q;
    logic signed [31:0] r2_a2y;
    logic signed [15:0] r2_z, r2_th;

    assign w_r2 = {1'b0, r1_xx} + {1'b0, r1_yy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_r2  <= w_r2;
            r2_p   <= $signed({1'b0, w_r2}) - $signed({3'b0, r1_dd});
            r2_q   <= $signed({2'b0, r1_ss}) - $signed({2'b0, w_r2});
            r2_e   <= $signed({3'b0, r1_a1sq}) - $signed({3'b0, r1_a2sq})
                      + $signed({r1_a2x[31], r1_a2x});
            r2_a2y <= r1_a2y;
            r2_z   <= r1_z;
            r2_th  <= r1_th;
        end
    end

    // stage 3: reachability and magnitudes
    logic               w_pneg, w_ppos, w_qneg, w_qpos;
    logic [32:0]        w_pabs;
    logic [33:0]        w_qabs;
    logic               r3_valid;
    logic [31:0]        r3_pm, r3_qm;
    t_sq                r3_s;

    assign w_pneg = r2_p[32];
    assign w_ppos = !r2_p[32] && (r2_p != '0);
    assign w_qneg = r2_q[33];
    assign w_qpos = !r2_q[33] && (r2_q != '0);
    assign w_pabs = w_pneg ? 33'(-r2_p) : 33'(r2_p);
    assign w_qabs = w_qneg ? 34'(-r2_q) : 34'(r2_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pm             <= w_pabs[31:0];
            r3_qm             <= w_qabs[31:0];
            r3_s.side.z       <= r2_z;
            r3_s.side.th      <= r2_th;
            r3_s.side.unreach <= (w_pneg && w_qpos) || (w_ppos && w_qneg);
            r3_s.d1           <= $signed({r2_e[32], r2_e}) + $signed({2'b0, r2_r2});
            r3_s.p            <= r2_p;
            r3_s.a2y          <= r2_a2y;
        end
    end

    // stage 4: P*Q
    logic [63:0]   w_prod;
    logic          r4_valid;
    logic [SQ_W-1:0] r4_prod;
    t_sq           r4_s;

    assign w_prod = r3_pm * r3_qm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_prod <= w_prod[SQ_W-1:0];
            r4_s    <= r3_s;
        end
    end

    // square root, one result bit per stage
    logic            w_sq_v [0:SQ_STEPS];
    logic [SQ_W-1:0] w_sq_n [0:SQ_STEPS];
    logic [SQ_W-1:0] w_sq_r [0:SQ_STEPS];
    t_sq             w_sq_s [0:SQ_STEPS];
    logic            r_sq_v [0:SQ_STEPS-1];
    logic [SQ_W-1:0] r_sq_n [0:SQ_STEPS-1];
    logic [SQ_W-1:0] r_sq_r [0:SQ_STEPS-1];
    t_sq             r_sq_s [0:SQ_STEPS-1];

    assign w_sq_v[0] = r4_valid;
    assign w_sq_n[0] = r4_prod;
    assign w_sq_r[0] = '0;
    assign w_sq_s[0] = r4_s;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W:0] B = (SQ_W+1)'(1) << (SQ_TOP - 2 * k);
        logic [SQ_W:0] w_sum;
        logic          w_ge;
        assign w_sum = {1'b0, w_sq_r[k]} + B;
        assign w_ge  = ({1'b0, w_sq_n[k]} >= w_sum);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k] <= w_sq_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_n[k] <= w_ge ? (w_sq_n[k] - w_sum[SQ_W-1:0]) : w_sq_n[k];
                r_sq_r[k] <= w_ge ? ((w_sq_r[k] >> 1) + B[SQ_W-1:0]) : (w_sq_r[k] >> 1);
                r_sq_s[k] <= w_sq_s[k];
            end
        end
        assign w_sq_v[k+1] = r_sq_v[k];
        assign w_sq_n[k+1] = r_sq_n[k];
        assign w_sq_r[k+1] = r_sq_r[k];
        assign w_sq_s[k+1] = r_sq_s[k];
    end

    // stage 5: atan operands
    logic [30:0]           w_s;
    logic signed [32:0]    w_n1;
    t_sq                   w_sq_o;
    logic                  r5_valid;
    logic signed [AT_W-1:0] r5_num1, r5_den1, r5_num2, r5_den2;
    t_side                 r5_s;

    assign w_sq_o = w_sq_s[SQ_STEPS];
    assign w_s    = w_sq_r[SQ_STEPS][30:0];
    assign w_n1   = $signed({w_sq_o.a2y[31], w_sq_o.a2y}) + $signed({2'b0, w_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= w_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_num1 <= {{2{w_n1[32]}}, w_n1};
            r5_den1 <= {w_sq_o.d1[33], w_sq_o.d1};
            r5_num2 <= {4'b0, w_s};
            r5_den2 <= {{2{w_sq_o.p[32]}}, w_sq_o.p};
            r5_s    <= w_sq_o.side;
        end
    end

    // atan lanes and matching side delay
    logic signed [ANG_W-1:0] w_t1, w_t2;
    logic                    w_dg1, w_dg2;

    tlik_atan #(.ITER(CORDIC_ITERATIONS)) u_atan_shoulder (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r5_num1),
        .i_den   (r5_den1),
        .o_ang   (w_t1),
        .o_degen (w_dg1)
    );

    tlik_atan #(.ITER(CORDIC_ITERATIONS)) u_atan_elbow (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r5_num2),
        .i_den   (r5_den2),
        .o_ang   (w_t2),
        .o_degen (w_dg2)
    );

    logic  w_ad_v [0:ATAN_LAT];
    t_side w_ad_s [0:ATAN_LAT];
    logic  r_ad_v [0:ATAN_LAT-1];
    t_side r_ad_s [0:ATAN_LAT-1];

    assign w_ad_v[0] = r5_valid;
    assign w_ad_s[0] = r5_s;

    for (genvar m = 0; m < ATAN_LAT; m++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ad_v[m] <= 1'b0;
            end else if (w_en) begin
                r_ad_v[m] <= w_ad_v[m];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ad_s[m] <= w_ad_s[m];
            end
        end
        assign w_ad_v[m+1] = r_ad_v[m];
        assign w_ad_s[m+1] = r_ad_s[m];
    end

    // stage 6: angle scaling and status
    logic signed [RW-1:0] w_v1, w_v2;
    t_side                w_ad_o;
    logic signed [14:0]   r6_q1, r6_q2;
    logic [1:0]           r6_status;
    logic signed [15:0]   r6_z, r6_th;

    assign w_ad_o = w_ad_s[ATAN_LAT];
    assign w_v1 = $signed({{3{w_t1[ANG_W-1]}}, w_t1, 1'b0}) + RND;
    assign w_v2 = RND - $signed({{3{w_t2[ANG_W-1]}}, w_t2, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= w_ad_v[ATAN_LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_q1 <= sat15(w_v1 >>> OSH);
            r6_q2 <= sat15(w_v2 >>> OSH);
            r6_z  <= w_ad_o.z;
            r6_th <= w_ad_o.th;
            if (w_ad_o.unreach)
                r6_status <= ST_UNREACH;
            else if (w_dg1 || w_dg2)
                r6_status <= ST_DEGEN;
            else
                r6_status <= ST_OK;
        end
    end

    // output register
    logic signed [17:0] w_wr;
    logic signed [16:0] w_wr_sat;
    logic signed [16:0] w_nz;
    logic signed [15:0] w_slide;
    logic               w_out_load;
    logic               w_out_zero;

    assign w_wr = $signed({{2{r6_th[15]}}, r6_th}) - $signed({{3{r6_q1[14]}}, r6_q1})
                  - $signed({{3{r6_q2[14]}}, r6_q2});
    assign w_wr_sat = (w_wr > 18'sd65535) ? 17'sh0FFFF :
                      (w_wr < -18'sd65536) ? 17'sh10000 : w_wr[16:0];
    assign w_nz    = -$signed({r6_z[15], r6_z});
    assign w_slide = (w_nz == 17'sd32768) ? 16'sh7FFF : w_nz[15:0];
    assign w_out_load = !(r_out_valid && i_stall);
    assign w_out_zero = (o_shoulder_angle == '0) && (o_elbow_angle == '0)
                        && (o_wrist_angle == '0) && (o_slide_travel == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_solve_status <= r6_status;
            if (r6_status == ST_OK) begin
                o_shoulder_angle <= r6_q1;
                o_elbow_angle    <= r6_q2;
                o_wrist_angle    <= w_wr_sat;
                o_slide_travel   <= w_slide;
            end else begin
                o_shoulder_angle <= '0;
                o_elbow_angle    <= '0;
                o_wrist_angle    <= '0;
                o_slide_travel   <= '0;
            end
        end
    end

    `ASSERT_IMP(a_fail_zeroes, i_clk, i_rst_n, o_valid && (o_solve_status != ST_OK), w_out_zero)
    `ASSERT_IMP(a_slide_sat, i_clk, i_rst_n, o_valid && (o_solve_status == ST_OK), o_slide_travel != 16'sh8000)
    `ASSERT_NXT(a_beat_enters, i_clk, i_rst_n, i_valid && !o_stall, r1_valid)
    `ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, o_valid && r6_valid && i_stall)

endmodule
`default_nettype wire

>>> src/tlik_atan.sv
// pipelined atan of a quotient: sign fold, normalizing shift, cordic vectoring
// depends on tlik_pkg
`default_nettype none
module tlik_atan import tlik_pkg::*; #(
    parameter int ITER = CORDIC_ITER_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AT_W-1:0]  i_num,
    input  logic signed [AT_W-1:0]  i_den,
    output logic signed [ANG_W-1:0] o_ang,
    output logic                    o_degen
);

    logic                   w_den_neg;
    logic [AT_W-1:0]        w_xabs;
    logic signed [AT_W:0]   w_y;
    logic [AT_W:0]          w_yabs;
    logic [AT_W:0]          w_mx;
    t_at_flag               w_f0;

    assign w_den_neg = i_den[AT_W-1];
    assign w_xabs    = w_den_neg ? AT_W'(-i_den) : AT_W'(i_den);
    assign w_y       = w_den_neg ? -{i_num[AT_W-1], i_num} : {i_num[AT_W-1], i_num};
    assign w_yabs    = w_y[AT_W] ? (AT_W+1)'(-w_y) : (AT_W+1)'(w_y);
    assign w_mx      = (w_yabs > {1'b0, w_xabs}) ? w_yabs : {1'b0, w_xabs};
    assign w_f0.zero_den = (i_den == '0);
    assign w_f0.num_pos  = !i_num[AT_W-1];
    assign w_f0.degen    = (i_den == '0) && (i_num == '0);

    logic signed [CW-1:0] r_x  [0:NORM_STEPS];
    logic signed [CW-1:0] r_y  [0:NORM_STEPS];
    logic [MX_W-1:0]      r_mx [0:NORM_STEPS];
    t_at_flag             r_f  [0:NORM_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= {{(CW-AT_W){1'b0}}, w_xabs};
            r_y[0]  <= {{(CW-AT_W-1){w_y[AT_W]}}, w_y};
            r_mx[0] <= {{(MX_W-AT_W-1){1'b0}}, w_mx};
            r_f[0]  <= w_f0;
        end
    end

    // shift left until the larger magnitude reaches the top bit
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic w_hit;
        assign w_hit = (r_mx[j][MX_W-1 -: SH] == '0);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j+1]  <= w_hit ? (r_x[j] <<< SH) : r_x[j];
                r_y[j+1]  <= w_hit ? (r_y[j] <<< SH) : r_y[j];
                r_mx[j+1] <= w_hit ? (r_mx[j] << SH) : r_mx[j];
                r_f[j+1]  <= r_f[j];
            end
        end
    end

    logic signed [CW-1:0]    w_cx [0:ITER];
    logic signed [CW-1:0]    w_cy [0:ITER];
    logic signed [ANG_W-1:0] w_cz [0:ITER];
    t_at_flag                w_cf [0:ITER];
    logic signed [CW-1:0]    r_cx [0:ITER-1];
    logic signed [CW-1:0]    r_cy [0:ITER-1];
    logic signed [ANG_W-1:0] r_cz [0:ITER-1];
    t_at_flag                r_cf [0:ITER-1];

    assign w_cx[0] = r_x[NORM_STEPS];
    assign w_cy[0] = r_y[NORM_STEPS];
    assign w_cz[0] = '0;
    assign w_cf[0] = r_f[NORM_STEPS];

    for (genvar i = 0; i < ITER; i++) begin : g_cordic
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;
        assign w_xs = w_cx[i] >>> i;
        assign w_ys = w_cy[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_cy[i][CW-1]) begin
                    r_cx[i] <= w_cx[i] + w_ys;
                    r_cy[i] <= w_cy[i] - w_xs;
                    r_cz[i] <= w_cz[i] + atan_tab(i);
                end else begin
                    r_cx[i] <= w_cx[i] - w_ys;
                    r_cy[i] <= w_cy[i] + w_xs;
                    r_cz[i] <= w_cz[i] - atan_tab(i);
                end
                r_cf[i] <= w_cf[i];
            end
        end
        assign w_cx[i+1] = r_cx[i];
        assign w_cy[i+1] = r_cy[i];
        assign w_cz[i+1] = r_cz[i];
        assign w_cf[i+1] = r_cf[i];
    end

    assign o_ang   = w_cf[ITER].zero_den ? (w_cf[ITER].num_pos ? ANG_90 : -ANG_90)
                                         : w_cz[ITER];
    assign o_degen = w_cf[ITER].degen;

endmodule
`default_nettype wire
